@@ sv/arpr_pkg.sv @@
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types and constants for the ARP resolver: command codes, result
// kinds, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package arpr_pkg;

   localparam int MAX_RESULTS = 16;

   // input command codes
   localparam logic [1:0] CMD_SEND = 2'd0;
   localparam logic [1:0] CMD_RECV = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_IPV4      = 3'd0;
   localparam logic [2:0] KIND_ARP_REQ   = 3'd1;
   localparam logic [2:0] KIND_ARP_REPLY = 3'd2;
   localparam logic [2:0] KIND_DELIVER   = 3'd3;
   localparam logic [2:0] KIND_DROP      = 3'd4;

   // frame and opcode values
   localparam logic [15:0] ETH_IPV4   = 16'h0800;
   localparam logic [15:0] ETH_ARP    = 16'h0806;
   localparam logic [15:0] OP_REQUEST = 16'd1;
   localparam logic [15:0] OP_REPLY   = 16'd2;
   localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

   // register indexes and reset values
   localparam logic [1:0]  REG_OWN_MAC  = 2'd0;
   localparam logic [1:0]  REG_OWN_IP   = 2'd1;
   localparam logic [1:0]  REG_LIFETIME = 2'd2;
   localparam logic [1:0]  REG_RETRY    = 2'd3;
   localparam logic [19:0] LIFETIME_RST = 20'd30000;
   localparam logic [19:0] RETRY_RST    = 20'd5000;

   // class of a received frame
   typedef enum logic [1:0] {
      RC_NONE    = 2'd0,
      RC_DELIVER = 2'd1,
      RC_REPLY   = 2'd2,
      RC_REQUEST = 2'd3
   } rclass_type;

   // which result the datapath loads into the output register
   typedef enum logic [2:0] {
      SEL_HIT     = 3'd0,
      SEL_REQ     = 3'd1,
      SEL_REPLY   = 3'd2,
      SEL_DELIVER = 3'd3,
      SEL_DROP    = 3'd4,
      SEL_FLUSH   = 3'd5
   } rsp_sel_type;

   typedef struct packed {
      logic        latch;
      logic        scan_start;
      logic        scan_pend;
      logic        scan_step;
      logic        now_add;
      logic        learn_write;
      logic        send_commit;
      logic        flush_start;
      logic        flush_read;
      logic        flush_next;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd_code;
      rclass_type rclass;
      logic       scan_done;
      logic       c_match;
      logic       p_match;
      logic       p_free;
      logic       p_full;
      logic       retry_quiet;
      logic       rsp_last;
   } status_type;

endpackage

@@ sv/arpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// arpr_ctrl
// Sequencer: dispatches each item, runs the cache and pending-host sweeps,
// commits table updates and walks the output beats.
// ----------------------------------------------------------------------------
module arpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  arpr_pkg::status_type st,
   output arpr_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DISP  = 9'b000000010,
      S_CSCAN = 9'b000000100,
      S_LEARN = 9'b000001000,
      S_PSCAN = 9'b000010000,
      S_SDEC  = 9'b000100000,
      S_FRD   = 9'b001000000,
      S_FLD   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_sel = arpr_pkg::SEL_HIT;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            case (st.cmd_code)
               arpr_pkg::CMD_SEND: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_CSCAN;
               end
               arpr_pkg::CMD_RECV: begin
                  case (st.rclass)
                     arpr_pkg::RC_DELIVER: begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_sel  = arpr_pkg::SEL_DELIVER;
                        state_in     = S_OUT;
                     end
                     arpr_pkg::RC_REPLY, arpr_pkg::RC_REQUEST: begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_CSCAN;
                     end
                     default: state_in = S_IDLE;
                  endcase
               end
               arpr_pkg::CMD_TICK: begin
                  cmd.now_add    = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = S_CSCAN;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_CSCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_done) begin
               if (st.cmd_code == arpr_pkg::CMD_TICK) begin
                  state_in = S_IDLE;
               end else if (st.cmd_code == arpr_pkg::CMD_SEND) begin
                  if (st.c_match) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = arpr_pkg::SEL_HIT;
                     state_in     = S_OUT;
                  end else begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_pend  = 1'b1;
                     state_in       = S_PSCAN;
                  end
               end else begin
                  state_in = S_LEARN;
               end
            end
         end
         S_LEARN: begin
            cmd.learn_write = 1'b1;
            if (st.rclass == arpr_pkg::RC_REPLY) begin
               cmd.scan_start = 1'b1;
               cmd.scan_pend  = 1'b1;
               state_in       = S_PSCAN;
            end else begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = arpr_pkg::SEL_REPLY;
               state_in     = S_OUT;
            end
         end
         S_PSCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_done) begin
               if (st.cmd_code == arpr_pkg::CMD_SEND) begin
                  state_in = S_SDEC;
               end else if (st.p_match) begin
                  cmd.flush_start = 1'b1;
                  state_in        = S_FRD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SDEC: begin
            if ((!st.p_match && !st.p_free) || (st.p_match && st.p_full)) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = arpr_pkg::SEL_DROP;
               state_in     = S_OUT;
            end else begin
               cmd.send_commit = 1'b1;
               if (st.p_match && st.retry_quiet) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = arpr_pkg::SEL_REQ;
                  state_in     = S_OUT;
               end
            end
         end
         S_FRD: begin
            cmd.flush_read = 1'b1;
            state_in       = S_FLD;
         end
         S_FLD: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = arpr_pkg::SEL_FLUSH;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (st.rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.flush_next = 1'b1;
                  state_in       = S_FRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/arpr_dp.sv @@
// ----------------------------------------------------------------------------
// arpr_dp
// Datapath: item and register storage, the millisecond clock, the cache and
// pending-host tables with their sweep unit, the tag queue memory and the
// output register.
// ----------------------------------------------------------------------------
module arpr_dp #(
   parameter int CACHE_ENTRIES = 16,
   parameter int PENDING_HOSTS = 8,
   parameter int PENDING_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  arpr_pkg::cmd_type    cmd,
   output arpr_pkg::status_type st,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [47:0]          csr_wdata,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_next_hop_ip,
   input  logic [7:0]           req_dgram_tag,
   input  logic [47:0]          req_frame_dst_mac,
   input  logic [15:0]          req_ethertype,
   input  logic                 req_parse_ok,
   input  logic [15:0]          req_arp_opcode,
   input  logic [31:0]          req_sender_ip,
   input  logic [47:0]          req_sender_mac,
   input  logic [31:0]          req_target_ip,
   input  logic [15:0]          req_elapsed_ms,
   output logic [2:0]           rsp_out_kind,
   output logic [47:0]          rsp_dst_mac,
   output logic [7:0]           rsp_out_tag,
   output logic [31:0]          rsp_arp_target,
   output logic                 rsp_last
);

   localparam int QCAP   = (PENDING_DEPTH < arpr_pkg::MAX_RESULTS) ?
                           PENDING_DEPTH : arpr_pkg::MAX_RESULTS;
   localparam int CW     = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int HW     = (PENDING_HOSTS > 1) ? $clog2(PENDING_HOSTS) : 1;
   localparam int TDEPTH = PENDING_HOSTS * QCAP;
   localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int SMAX   = (CACHE_ENTRIES > PENDING_HOSTS) ? CACHE_ENTRIES : PENDING_HOSTS;
   localparam int SW     = $clog2(SMAX + 1);

   // configuration
   logic [47:0] own_mac_ff;
   logic [31:0] own_ip_ff;
   logic [19:0] life_ff;
   logic [19:0] retry_ff;

   // latched item
   logic [1:0]  cmd_ff;
   logic [31:0] hop_ip_ff;
   logic [7:0]  tag_ff;
   logic [47:0] fdst_ff;
   logic [15:0] etype_ff;
   logic        pok_ff;
   logic [15:0] op_ff;
   logic [31:0] sip_ff;
   logic [47:0] smac_ff;
   logic [31:0] tip_ff;
   logic [15:0] elapsed_ff;

   logic [31:0] now_ff;

   // cache table
   logic [31:0] c_ip_mem    [CACHE_ENTRIES];
   logic [47:0] c_mac_mem   [CACHE_ENTRIES];
   logic [31:0] c_stamp_mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] c_valid_ff;
   logic [31:0] c_rd_ip_ff;
   logic [47:0] c_rd_mac_ff;
   logic [31:0] c_rd_stamp_ff;

   // pending hosts
   logic [31:0] p_ip_mem    [PENDING_HOSTS];
   logic [31:0] p_stamp_mem [PENDING_HOSTS];
   logic [4:0]  p_count_ff  [PENDING_HOSTS];
   logic [31:0] p_rd_ip_ff;
   logic [31:0] p_rd_stamp_ff;
   logic [7:0]  t_mem [TDEPTH];
   logic [7:0]  t_rd_ff;

   // sweep unit
   logic [SW-1:0] sc_cnt_ff;
   logic [SW-1:0] sc_eidx_ff;
   logic          sc_ev_ff;
   logic          sc_pend_ff;
   logic [SW-1:0] sc_limit;

   // sweep results
   logic          cm_ff, cf_ff, pm_ff, pf_ff;
   logic [CW-1:0] cm_idx_ff, cf_idx_ff, old_idx_ff;
   logic [47:0]   cm_mac_ff;
   logic [31:0]   old_age_ff;
   logic [HW-1:0] pm_idx_ff, pf_idx_ff;
   logic [31:0]   pm_stamp_ff;

   // flush walk
   logic [4:0]    fl_k_ff;
   logic [4:0]    fl_n_ff;

   logic [31:0]   key;
   logic [CW-1:0] c_eidx;
   logic [HW-1:0] p_eidx;
   logic [31:0]   c_age;
   logic [CW-1:0] learn_slot;
   logic [HW-1:0] s_host;
   logic [4:0]    s_k;
   logic [4:0]    pm_count;
   logic [TW-1:0] t_waddr;
   logic [TW-1:0] t_raddr;
   logic          s_stamp_wr;
   arpr_pkg::rclass_type rclass;

   assign key        = (cmd_ff == arpr_pkg::CMD_SEND) ? hop_ip_ff : sip_ff;
   assign sc_limit   = sc_pend_ff ? SW'(PENDING_HOSTS) : SW'(CACHE_ENTRIES);
   assign c_eidx     = sc_eidx_ff[CW-1:0];
   assign p_eidx     = sc_eidx_ff[HW-1:0];
   assign c_age      = now_ff - c_rd_stamp_ff;
   assign learn_slot = cm_ff ? cm_idx_ff : (cf_ff ? cf_idx_ff : old_idx_ff);
   assign pm_count   = p_count_ff[pm_idx_ff];
   assign s_host     = pm_ff ? pm_idx_ff : pf_idx_ff;
   assign s_k        = pm_ff ? pm_count : 5'd0;
   assign t_waddr    = TW'(s_host * QCAP) + TW'(s_k);
   assign t_raddr    = TW'(pm_idx_ff * QCAP) + TW'(fl_k_ff);
   assign s_stamp_wr = !pm_ff || !st.retry_quiet;

   // classify a received frame
   always_comb begin
      rclass = arpr_pkg::RC_NONE;
      if ((fdst_ff == own_mac_ff || fdst_ff == arpr_pkg::MAC_BCAST) && pok_ff) begin
         if (etype_ff == arpr_pkg::ETH_IPV4) begin
            rclass = arpr_pkg::RC_DELIVER;
         end else if (etype_ff == arpr_pkg::ETH_ARP) begin
            if (op_ff == arpr_pkg::OP_REPLY) begin
               rclass = arpr_pkg::RC_REPLY;
            end else if (op_ff == arpr_pkg::OP_REQUEST && tip_ff == own_ip_ff) begin
               rclass = arpr_pkg::RC_REQUEST;
            end
         end
      end
   end

   // status to the controller
   always_comb begin
      st.cmd_code    = cmd_ff;
      st.rclass      = rclass;
      st.scan_done   = (sc_cnt_ff == sc_limit) && !sc_ev_ff;
      st.c_match     = cm_ff;
      st.p_match     = pm_ff;
      st.p_free      = pf_ff;
      st.p_full      = (pm_count >= 5'(QCAP));
      st.retry_quiet = ((now_ff - pm_stamp_ff) < {12'd0, retry_ff});
      st.rsp_last    = rsp_last;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         own_ip_ff  <= '0;
         life_ff    <= arpr_pkg::LIFETIME_RST;
         retry_ff   <= arpr_pkg::RETRY_RST;
      end else if (csr_we) begin
         case (csr_index)
            arpr_pkg::REG_OWN_MAC:  own_mac_ff <= csr_wdata;
            arpr_pkg::REG_OWN_IP:   own_ip_ff  <= csr_wdata[31:0];
            arpr_pkg::REG_LIFETIME: life_ff    <= csr_wdata[19:0];
            arpr_pkg::REG_RETRY:    retry_ff   <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff     <= req_cmd;
         hop_ip_ff  <= req_next_hop_ip;
         tag_ff     <= req_dgram_tag;
         fdst_ff    <= req_frame_dst_mac;
         etype_ff   <= req_ethertype;
         pok_ff     <= req_parse_ok;
         op_ff      <= req_arp_opcode;
         sip_ff     <= req_sender_ip;
         smac_ff    <= req_sender_mac;
         tip_ff     <= req_target_ip;
         elapsed_ff <= req_elapsed_ms;
      end
   end

   // millisecond clock
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else if (cmd.now_add) begin
         now_ff <= now_ff + {16'd0, elapsed_ff};
      end
   end

   // sweep counter, one entry read per cycle, evaluated from the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         sc_cnt_ff  <= '0;
         sc_ev_ff   <= 1'b0;
         sc_pend_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         sc_cnt_ff  <= '0;
         sc_ev_ff   <= 1'b0;
         sc_pend_ff <= cmd.scan_pend;
      end else if (cmd.scan_step) begin
         if (sc_cnt_ff != sc_limit) begin
            sc_cnt_ff <= sc_cnt_ff + 1'b1;
            sc_ev_ff  <= 1'b1;
         end else begin
            sc_ev_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sc_eidx_ff <= sc_cnt_ff;
   end

   // cache memory
   always_ff @(posedge clock) begin
      c_rd_ip_ff    <= c_ip_mem[sc_cnt_ff[CW-1:0]];
      c_rd_mac_ff   <= c_mac_mem[sc_cnt_ff[CW-1:0]];
      c_rd_stamp_ff <= c_stamp_mem[sc_cnt_ff[CW-1:0]];
      if (cmd.learn_write) begin
         c_ip_mem[learn_slot]    <= sip_ff;
         c_mac_mem[learn_slot]   <= smac_ff;
         c_stamp_mem[learn_slot] <= now_ff;
      end
   end

   // cache valid bits: learn sets, tick sweep expires
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= '0;
      end else if (cmd.learn_write) begin
         c_valid_ff[learn_slot] <= 1'b1;
      end else if (sc_ev_ff && !sc_pend_ff && cmd_ff == arpr_pkg::CMD_TICK) begin
         if (c_valid_ff[c_eidx] && c_age >= {12'd0, life_ff}) begin
            c_valid_ff[c_eidx] <= 1'b0;
         end
      end
   end

   // cache sweep results
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         cm_ff <= 1'b0;
         cf_ff <= 1'b0;
      end else if (sc_ev_ff && !sc_pend_ff) begin
         if (!cm_ff && c_valid_ff[c_eidx] && c_rd_ip_ff == key) begin
            cm_ff     <= 1'b1;
            cm_idx_ff <= c_eidx;
            cm_mac_ff <= c_rd_mac_ff;
         end
         if (!cf_ff && !c_valid_ff[c_eidx]) begin
            cf_ff     <= 1'b1;
            cf_idx_ff <= c_eidx;
         end
         if (c_eidx == '0 || c_age > old_age_ff) begin
            old_age_ff <= c_age;
            old_idx_ff <= c_eidx;
         end
      end
   end

   // pending host memory
   always_ff @(posedge clock) begin
      p_rd_ip_ff    <= p_ip_mem[sc_cnt_ff[HW-1:0]];
      p_rd_stamp_ff <= p_stamp_mem[sc_cnt_ff[HW-1:0]];
      if (cmd.send_commit && s_stamp_wr) begin
         p_ip_mem[s_host]    <= hop_ip_ff;
         p_stamp_mem[s_host] <= now_ff;
      end
   end

   // pending host sweep results
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         pm_ff <= 1'b0;
         pf_ff <= 1'b0;
      end else if (sc_ev_ff && sc_pend_ff) begin
         if (!pm_ff && p_count_ff[p_eidx] != 5'd0 && p_rd_ip_ff == key) begin
            pm_ff       <= 1'b1;
            pm_idx_ff   <= p_eidx;
            pm_stamp_ff <= p_rd_stamp_ff;
         end
         if (!pf_ff && p_count_ff[p_eidx] == 5'd0) begin
            pf_ff     <= 1'b1;
            pf_idx_ff <= p_eidx;
         end
      end
   end

   // queue fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PENDING_HOSTS; i++) begin
            p_count_ff[i] <= '0;
         end
      end else if (cmd.send_commit) begin
         p_count_ff[s_host] <= s_k + 5'd1;
      end else if (cmd.flush_start) begin
         p_count_ff[pm_idx_ff] <= '0;
      end
   end

   // tag queue memory
   always_ff @(posedge clock) begin
      if (cmd.send_commit) begin
         t_mem[t_waddr] <= tag_ff;
      end
      if (cmd.flush_read) begin
         t_rd_ff <= t_mem[t_raddr];
      end
   end

   // flush walk
   always_ff @(posedge clock) begin
      if (cmd.flush_start) begin
         fl_k_ff <= '0;
         fl_n_ff <= pm_count;
      end else if (cmd.flush_next) begin
         fl_k_ff <= fl_k_ff + 5'd1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_dst_mac    <= '0;
         rsp_out_tag    <= '0;
         rsp_arp_target <= '0;
         rsp_last       <= 1'b1;
         case (cmd.rsp_sel)
            arpr_pkg::SEL_HIT: begin
               rsp_out_kind <= arpr_pkg::KIND_IPV4;
               rsp_dst_mac  <= cm_mac_ff;
               rsp_out_tag  <= tag_ff;
            end
            arpr_pkg::SEL_REQ: begin
               rsp_out_kind   <= arpr_pkg::KIND_ARP_REQ;
               rsp_dst_mac    <= arpr_pkg::MAC_BCAST;
               rsp_arp_target <= hop_ip_ff;
            end
            arpr_pkg::SEL_REPLY: begin
               rsp_out_kind   <= arpr_pkg::KIND_ARP_REPLY;
               rsp_dst_mac    <= smac_ff;
               rsp_arp_target <= sip_ff;
            end
            arpr_pkg::SEL_DELIVER: begin
               rsp_out_kind <= arpr_pkg::KIND_DELIVER;
            end
            arpr_pkg::SEL_DROP: begin
               rsp_out_kind <= arpr_pkg::KIND_DROP;
               rsp_out_tag  <= tag_ff;
            end
            arpr_pkg::SEL_FLUSH: begin
               rsp_out_kind <= arpr_pkg::KIND_IPV4;
               rsp_dst_mac  <= smac_ff;
               rsp_out_tag  <= t_rd_ff;
               rsp_last     <= (fl_k_ff + 5'd1 == fl_n_ff);
            end
            default: rsp_out_kind <= arpr_pkg::KIND_DROP;
         endcase
      end
   end

endmodule

@@ sv/arp_resolver_with_pending_queue_top.sv @@
// One item at a time; the one-entry-per-cycle table sweep sets the rate while rsp_stall is low.
// Reset (synchronous): clears cache valid bits, queue counts and the ms clock, and
// loads config register defaults; table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// arp_resolver_with_pending_queue_top
// ARP resolver top: controller and datapath joined by command/status bundles.
// ----------------------------------------------------------------------------
module arp_resolver_with_pending_queue_top #(
   parameter int CACHE_ENTRIES = 16,
   parameter int PENDING_HOSTS = 8,
   parameter int PENDING_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_next_hop_ip,
   input  logic [7:0]  req_dgram_tag,
   input  logic [47:0] req_frame_dst_mac,
   input  logic [15:0] req_ethertype,
   input  logic        req_parse_ok,
   input  logic [15:0] req_arp_opcode,
   input  logic [31:0] req_sender_ip,
   input  logic [47:0] req_sender_mac,
   input  logic [31:0] req_target_ip,
   input  logic [15:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_out_kind,
   output logic [47:0] rsp_dst_mac,
   output logic [7:0]  rsp_out_tag,
   output logic [31:0] rsp_arp_target,
   output logic        rsp_last
);

   arpr_pkg::cmd_type    cmd;
   arpr_pkg::status_type st;

   arpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   arpr_dp #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .PENDING_HOSTS (PENDING_HOSTS),
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_cmd           (req_cmd),
      .req_next_hop_ip   (req_next_hop_ip),
      .req_dgram_tag     (req_dgram_tag),
      .req_frame_dst_mac (req_frame_dst_mac),
      .req_ethertype     (req_ethertype),
      .req_parse_ok      (req_parse_ok),
      .req_arp_opcode    (req_arp_opcode),
      .req_sender_ip     (req_sender_ip),
      .req_sender_mac    (req_sender_mac),
      .req_target_ip     (req_target_ip),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_dst_mac       (rsp_dst_mac),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_arp_target    (rsp_arp_target),
      .rsp_last          (rsp_last)
   );

endmodule
